// ===== rtl/core/mf3_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mf3_pkg
// Shared constants and types of the 3x3 median filter: image limits, field
// widths, register indexes and the packed item types of both channels.
// ----------------------------------------------------------------------------
package mf3_pkg;

   localparam int MAX_WIDTH  = 2048;
   localparam int MAX_HEIGHT = 2048;

   localparam int PIX_W     = 8;
   localparam int DIM_W     = 12;
   localparam int COL_W     = $clog2(MAX_WIDTH);
   localparam int ROW_W     = $clog2(MAX_HEIGHT);
   localparam int INROW_W   = $clog2(MAX_HEIGHT + 2);
   localparam int CMP_W     = DIM_W + 1;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_WIDTH  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_HEIGHT = CSR_IDX_W'(1);

   localparam logic [DIM_W-1:0] RESET_WIDTH  = DIM_W'(640);
   localparam logic [DIM_W-1:0] RESET_HEIGHT = DIM_W'(480);

   localparam logic KIND_PIXEL = 1'b0;
   localparam logic KIND_FLUSH = 1'b1;

   typedef logic [PIX_W-1:0] pixel_type;
   typedef pixel_type [2:0] trio_type;
   typedef trio_type [2:0] grid_type;

   typedef struct packed {
      logic      kind;
      pixel_type pixel_in;
   } req_type;

   typedef struct packed {
      pixel_type median_out;
      logic      frame_last;
   } rsp_type;

endpackage

// ===== rtl/core/mf3_line_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mf3_line_store
// The two row memories. Store A holds the row above the input position and
// store B the row two above. A read returns both entries registered, in the
// next cycle; the old A entry moves from the read register into B on b_we.
// ----------------------------------------------------------------------------
module mf3_line_store (
   input  logic                     clock,
   input  logic                     rd_en,
   input  logic [mf3_pkg::COL_W-1:0] rd_addr,
   input  mf3_pkg::pixel_type       wr_data,
   input  logic                     b_we,
   input  logic [mf3_pkg::COL_W-1:0] b_addr,
   output mf3_pkg::pixel_type       rd_a,
   output mf3_pkg::pixel_type       rd_b
);
   import mf3_pkg::*;

   pixel_type store_a [MAX_WIDTH];
   pixel_type store_b [MAX_WIDTH];
   pixel_type rd_a_ff;
   pixel_type rd_b_ff;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_a_ff <= store_a[rd_addr];
         store_a[rd_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_b_ff <= store_b[rd_addr];
      end
      if (b_we) begin
         store_b[b_addr] <= rd_a_ff;
      end
   end

   assign rd_a = rd_a_ff;
   assign rd_b = rd_b_ff;

endmodule

// ===== rtl/core/mf3_median.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mf3_median
// Two-stage median of nine: the first stage sorts each row of three, the
// second takes the median of the row minima maximum, the median of the
// middles and the row maxima minimum. Ends in the result register.
// ----------------------------------------------------------------------------
module mf3_median (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  mf3_pkg::grid_type  in_taps,
   input  logic               in_last,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output mf3_pkg::rsp_type   rsp_data
);
   import mf3_pkg::*;

   function automatic pixel_type max2(input pixel_type a, input pixel_type b);
      return (a > b) ? a : b;
   endfunction

   function automatic pixel_type min2(input pixel_type a, input pixel_type b);
      return (a < b) ? a : b;
   endfunction

   function automatic pixel_type med3(input pixel_type a, input pixel_type b,
                                      input pixel_type c);
      return max2(min2(a, b), min2(max2(a, b), c));
   endfunction

   function automatic trio_type sort3(input trio_type t);
      pixel_type a;
      pixel_type b;
      pixel_type c;
      pixel_type x;
      a = t[0];
      b = t[1];
      c = t[2];
      if (a > b) begin
         x = a; a = b; b = x;
      end
      if (b > c) begin
         x = b; b = c; c = x;
      end
      if (a > b) begin
         x = a; a = b; b = x;
      end
      return {c, b, a};
   endfunction

   logic      s3_valid_ff, s3_valid_in;
   logic      s3_last_ff;
   grid_type  s3_sorted_ff, s3_sorted_in;
   logic      out_valid_ff, out_valid_in;
   rsp_type   out_data_ff, out_data_in;
   logic      out_free;
   logic      s3_move;
   logic      in_move;
   pixel_type lo_max, mid_med, hi_min;

   assign out_free = !out_valid_ff || rsp_ready;
   assign s3_move  = s3_valid_ff && out_free;
   assign in_ready = !s3_valid_ff || out_free;
   assign in_move  = in_valid && in_ready;

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         s3_sorted_in[r] = sort3(in_taps[r]);
      end
      s3_valid_in = in_move ? 1'b1 : (s3_move ? 1'b0 : s3_valid_ff);

      lo_max  = max2(max2(s3_sorted_ff[0][0], s3_sorted_ff[1][0]), s3_sorted_ff[2][0]);
      mid_med = med3(s3_sorted_ff[0][1], s3_sorted_ff[1][1], s3_sorted_ff[2][1]);
      hi_min  = min2(min2(s3_sorted_ff[0][2], s3_sorted_ff[1][2]), s3_sorted_ff[2][2]);
      out_data_in.median_out = med3(lo_max, mid_med, hi_min);
      out_data_in.frame_last = s3_last_ff;
      out_valid_in = s3_move ? 1'b1 : (rsp_ready ? 1'b0 : out_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff  <= s3_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_move) begin
         s3_sorted_ff <= s3_sorted_in;
         s3_last_ff   <= in_last;
      end
      if (s3_move) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

// ===== rtl/core/median_filter_3x3.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// median_filter_3x3
// 3x3 median filter with replicated borders over a raster stream of 8-bit
// pixels, with two row memories, a 3x3 window and a pipelined median.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle and sustains that rate while
// results are taken; each row memory does one read and one write per cycle,
// which is what sets the pace. An item passes four register stages (row
// memory read, window, row sort, median), and the result it releases is
// offered from the median register. A pixel's result follows one row plus
// one pixel of input later, so after the last pixel the host sends
// image_width + 1 flush items to drain the frame. Register writes restart
// the frame; the user must make them while no item is in flight, as the
// block does not enforce it. Row memories need no clearing after reset.
module median_filter_3x3 (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  mf3_pkg::req_type              req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output mf3_pkg::rsp_type              rsp_data,
   input  logic                          csr_we,
   input  logic [mf3_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [mf3_pkg::DIM_W-1:0]     csr_wdata
);
   import mf3_pkg::*;

   typedef struct packed {
      logic row_first;
      logic row_last;
      logic col_first;
      logic col_last;
      logic last;
   } sel_type;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                  input logic [DIM_W-1:0] hi);
      if (v < DIM_W'(2)) begin
         return DIM_W'(2);
      end
      if (v > hi) begin
         return hi;
      end
      return v;
   endfunction

   logic [DIM_W-1:0]   width_ff, width_in;
   logic [DIM_W-1:0]   height_ff, height_in;
   logic [COL_W-1:0]   in_column_ff, in_column_in;
   logic [INROW_W-1:0] in_row_ff, in_row_in;
   logic [COL_W-1:0]   out_column_ff, out_column_in;
   logic [ROW_W-1:0]   out_row_ff, out_row_in;

   logic               s1_valid_ff, s1_valid_in;
   logic [COL_W-1:0]   s1_addr_ff;
   pixel_type          s1_val_ff;
   logic               s1_emit_ff;
   sel_type            s1_sel_ff;

   grid_type           window_ff, window_in;
   grid_type           shifted;
   grid_type           taps_in;
   grid_type           s2_taps_ff;
   logic               s2_valid_ff, s2_valid_in;
   logic               s2_last_ff;

   logic [CMP_W-1:0]   w_cmp, h_cmp;
   logic               pixels_due;
   logic               ignore_item;
   logic               item_go;
   logic               emit;
   logic               col_wrap;
   sel_type            sel;
   pixel_type          val;
   pixel_type          rd_a, rd_b;
   logic               s1_move, s2_move, s2_free;
   logic               med_in_ready;
   logic [1:0]         rsel [3];
   logic [1:0]         csel [3];

   assign w_cmp       = CMP_W'(width_ff);
   assign h_cmp       = CMP_W'(height_ff);
   assign pixels_due  = CMP_W'(in_row_ff) < h_cmp;
   assign ignore_item = (req_data.kind == KIND_FLUSH) && pixels_due;
   assign val         = pixels_due ? req_data.pixel_in : '0;

   assign s2_free   = !s2_valid_ff || med_in_ready;
   assign s1_move   = s1_valid_ff && s2_free;
   assign s2_move   = s2_valid_ff && med_in_ready;
   assign req_ready = !s1_valid_ff || s2_free;
   assign item_go   = req_valid && req_ready && !ignore_item;

   assign emit = (CMP_W'(in_row_ff) >= CMP_W'(2))
              || ((CMP_W'(in_row_ff) == CMP_W'(1)) && (in_column_ff != '0));
   assign col_wrap = CMP_W'(in_column_ff) + CMP_W'(1) >= w_cmp;

   assign sel.row_first = (out_row_ff == '0);
   assign sel.row_last  = CMP_W'(out_row_ff) >= h_cmp - CMP_W'(1);
   assign sel.col_first = (out_column_ff == '0);
   assign sel.col_last  = CMP_W'(out_column_ff) >= w_cmp - CMP_W'(1);
   assign sel.last      = (CMP_W'(out_row_ff) == h_cmp - CMP_W'(1))
                       && (CMP_W'(out_column_ff) == w_cmp - CMP_W'(1));

   always_comb begin
      width_in      = width_ff;
      height_in     = height_ff;
      in_column_in  = in_column_ff;
      in_row_in     = in_row_ff;
      out_column_in = out_column_ff;
      out_row_in    = out_row_ff;
      if (csr_we) begin
         if (csr_index == REG_IMAGE_WIDTH) begin
            width_in = clamp_dim(csr_wdata, DIM_W'(MAX_WIDTH));
         end
         if (csr_index == REG_IMAGE_HEIGHT) begin
            height_in = clamp_dim(csr_wdata, DIM_W'(MAX_HEIGHT));
         end
         in_column_in  = '0;
         in_row_in     = '0;
         out_column_in = '0;
         out_row_in    = '0;
      end else if (item_go) begin
         if (col_wrap) begin
            in_column_in = '0;
            in_row_in    = in_row_ff + INROW_W'(1);
         end else begin
            in_column_in = in_column_ff + COL_W'(1);
         end
         if (emit) begin
            if (sel.last) begin
               in_column_in  = '0;
               in_row_in     = '0;
               out_column_in = '0;
               out_row_in    = '0;
            end else if (sel.col_last) begin
               out_column_in = '0;
               out_row_in    = out_row_ff + ROW_W'(1);
            end else begin
               out_column_in = out_column_ff + COL_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff      <= RESET_WIDTH;
         height_ff     <= RESET_HEIGHT;
         in_column_ff  <= '0;
         in_row_ff     <= '0;
         out_column_ff <= '0;
         out_row_ff    <= '0;
      end else begin
         width_ff      <= width_in;
         height_ff     <= height_in;
         in_column_ff  <= in_column_in;
         in_row_ff     <= in_row_in;
         out_column_ff <= out_column_in;
         out_row_ff    <= out_row_in;
      end
   end

   mf3_line_store u_line_store (
      .clock   (clock),
      .rd_en   (item_go),
      .rd_addr (in_column_ff),
      .wr_data (val),
      .b_we    (s1_move),
      .b_addr  (s1_addr_ff),
      .rd_a    (rd_a),
      .rd_b    (rd_b)
   );

   assign s1_valid_in = item_go ? 1'b1 : (s1_move ? 1'b0 : s1_valid_ff);

   always_ff @(posedge clock) begin
      if (item_go) begin
         s1_addr_ff <= in_column_ff;
         s1_val_ff  <= val;
         s1_emit_ff <= emit;
         s1_sel_ff  <= sel;
      end
   end

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         shifted[r][0] = window_ff[r][1];
         shifted[r][1] = window_ff[r][2];
      end
      shifted[0][2] = rd_b;
      shifted[1][2] = rd_a;
      shifted[2][2] = s1_val_ff;

      rsel[0] = s1_sel_ff.row_first ? 2'd1 : 2'd0;
      rsel[1] = 2'd1;
      rsel[2] = s1_sel_ff.row_last ? 2'd1 : 2'd2;
      csel[0] = s1_sel_ff.col_first ? 2'd1 : 2'd0;
      csel[1] = 2'd1;
      csel[2] = s1_sel_ff.col_last ? 2'd1 : 2'd2;
      for (int r = 0; r < 3; r++) begin
         for (int q = 0; q < 3; q++) begin
            taps_in[r][q] = shifted[rsel[r]][csel[q]];
         end
      end

      if (csr_we) begin
         window_in = '0;
      end else if (s1_move) begin
         window_in = s1_sel_ff.last && s1_emit_ff ? '0 : shifted;
      end else begin
         window_in = window_ff;
      end

      s2_valid_in = (s1_move && s1_emit_ff) ? 1'b1 : (s2_move ? 1'b0 : s2_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         window_ff   <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         window_ff   <= window_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move && s1_emit_ff) begin
         s2_taps_ff <= taps_in;
         s2_last_ff <= s1_sel_ff.last;
      end
   end

   mf3_median u_median (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s2_valid_ff),
      .in_ready  (med_in_ready),
      .in_taps   (s2_taps_ff),
      .in_last   (s2_last_ff),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // The input column never reaches the row length.
   a_column_in_row: assert property (@(posedge clock) disable iff (reset)
      CMP_W'(in_column_ff) < w_cmp)
      else $error("input column beyond row length");

   // The output row never passes the last row of the frame.
   a_out_row_bound: assert property (@(posedge clock) disable iff (reset)
      CMP_W'(out_row_ff) < h_cmp)
      else $error("output row beyond frame height");

   // Draining never takes the input row past the second row below the frame.
   a_drain_bound: assert property (@(posedge clock) disable iff (reset)
      CMP_W'(in_row_ff) <= h_cmp + CMP_W'(1))
      else $error("drain ran past the frame end");

   // Row memory data waiting for the window must hold while that stage stalls.
   a_read_held: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s2_free) |=> ((rd_a === $past(rd_a)) && (rd_b === $past(rd_b))))
      else $error("row memory data lost during a stall");

endmodule

// ===== tb/median_filter_3x3_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// median_filter_3x3_checker
// Watches the item, result and register ports of the 3x3 median filter, keeps
// its own copy of the line stores, window and position counters, predicts the
// median and frame marker for every accepted item that yields a result, and
// compares each accepted result field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module median_filter_3x3_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  mf3_pkg::req_type              req_data,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  mf3_pkg::rsp_type              rsp_data,
   input  logic                          csr_we,
   input  logic [mf3_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [mf3_pkg::DIM_W-1:0]     csr_wdata,
   output int                            pending_results,
   output int                            results_checked,
   output int                            frames_completed,
   output int                            mismatch_count
);
   import mf3_pkg::*;

   localparam int MEDIAN_RANK  = 4;
   localparam int REPORT_LIMIT = 100;

   logic [DIM_W-1:0] width_reg;
   logic [DIM_W-1:0] height_reg;
   pixel_type        row_above     [MAX_WIDTH];
   pixel_type        row_two_above [MAX_WIDTH];
   pixel_type [8:0]  window;
   int unsigned      in_col;
   int unsigned      in_row;
   int unsigned      out_col;
   int unsigned      out_row;
   rsp_type          expected_medians [$];

   function automatic int unsigned clamp_dim(input logic [DIM_W-1:0] raw,
                                             input int unsigned hi);
      if (raw < 2) return 2;
      if (raw > hi) return hi;
      return raw;
   endfunction

   function automatic void restart_frame();
      window  = '0;
      in_col  = 0;
      in_row  = 0;
      out_col = 0;
      out_row = 0;
   endfunction

   // The median is the value with at most four taps below it and more than
   // four taps at or below it.
   function automatic pixel_type median_of_nine(input pixel_type [8:0] taps);
      int below;
      int not_above;
      for (int i = 0; i < 9; i++) begin
         below     = 0;
         not_above = 0;
         for (int j = 0; j < 9; j++) begin
            if (taps[j] < taps[i]) below++;
            if (taps[j] <= taps[i]) not_above++;
         end
         if (below <= MEDIAN_RANK && not_above > MEDIAN_RANK) return taps[i];
      end
      return '0;
   endfunction

   function automatic bit predict_median(input req_type item, output rsp_type res);
      int unsigned     w;
      int unsigned     h;
      int unsigned     c;
      int unsigned     rsel [0:2];
      int unsigned     csel [0:2];
      bit              emit;
      bit              last;
      pixel_type       val;
      pixel_type [8:0] taps;
      w   = clamp_dim(width_reg, MAX_WIDTH);
      h   = clamp_dim(height_reg, MAX_HEIGHT);
      res = '0;
      if (item.kind == KIND_FLUSH && in_row < h) return 1'b0;

      val = (in_row < h) ? item.pixel_in : '0;
      c   = (in_col < w) ? in_col : w - 1;
      for (int k = 0; k < 3; k++) begin
         window[3*k]   = window[3*k+1];
         window[3*k+1] = window[3*k+2];
      end
      window[2]        = row_two_above[c];
      window[5]        = row_above[c];
      window[8]        = val;
      row_two_above[c] = row_above[c];
      row_above[c]     = val;

      emit = (in_row >= 2) || (in_row == 1 && in_col >= 1);
      in_col++;
      if (in_col >= w) begin
         in_col = 0;
         in_row++;
      end
      if (!emit) return 1'b0;

      last    = (out_row == h - 1) && (out_col == w - 1);
      rsel[0] = (out_row == 0) ? 1 : 0;
      rsel[1] = 1;
      rsel[2] = (out_row >= h - 1) ? 1 : 2;
      csel[0] = (out_col == 0) ? 1 : 0;
      csel[1] = 1;
      csel[2] = (out_col >= w - 1) ? 1 : 2;
      for (int r = 0; r < 3; r++) begin
         for (int q = 0; q < 3; q++) begin
            taps[3*r+q] = window[3*rsel[r] + csel[q]];
         end
      end
      res.median_out = median_of_nine(taps);
      res.frame_last = last;

      if (last) begin
         restart_frame();
      end else begin
         out_col++;
         if (out_col >= w) begin
            out_col = 0;
            out_row++;
         end
      end
      return 1'b1;
   endfunction

   function automatic bit log_mismatch();
      mismatch_count++;
      if (mismatch_count == REPORT_LIMIT + 1) begin
         $display("%0t: further mismatch reports suppressed", $time);
      end
      return mismatch_count <= REPORT_LIMIT;
   endfunction

   always @(posedge clock) begin : monitor
      rsp_type predicted;
      rsp_type want;
      if (reset) begin
         width_reg  = RESET_WIDTH;
         height_reg = RESET_HEIGHT;
         for (int i = 0; i < MAX_WIDTH; i++) begin
            row_above[i]     = '0;
            row_two_above[i] = '0;
         end
         restart_frame();
         expected_medians.delete();
         results_checked  = 0;
         frames_completed = 0;
         mismatch_count   = 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_IMAGE_WIDTH:  width_reg = csr_wdata;
               REG_IMAGE_HEIGHT: height_reg = csr_wdata;
               default: ;
            endcase
            restart_frame();
         end
         if (req_valid && req_ready) begin
            if (predict_median(req_data, predicted)) expected_medians.push_back(predicted);
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_medians.size() == 0) begin
               if (log_mismatch()) begin
                  $display("%0t: result with none expected, got median_out %0d frame_last %0b",
                           $time, rsp_data.median_out, rsp_data.frame_last);
               end
            end else begin
               want = expected_medians.pop_front();
               results_checked++;
               if (want.frame_last) frames_completed++;
               if (rsp_data.median_out !== want.median_out && log_mismatch()) begin
                  $display("%0t: median_out expected %0d, got %0d",
                           $time, want.median_out, rsp_data.median_out);
               end
               if (rsp_data.frame_last !== want.frame_last && log_mismatch()) begin
                  $display("%0t: frame_last expected %0b, got %0b",
                           $time, want.frame_last, rsp_data.frame_last);
               end
            end
         end
      end
      pending_results = expected_medians.size();
   end

endmodule

// ===== tb/median_filter_3x3_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// median_filter_3x3_tb
// Drives pixel frames into the 3x3 median filter: a short directed frame set
// for borders, clamped sizes and ignored or reused items, a short burst at
// sizes above the maximum, then random small frames with aborted frames,
// stray items and changing idle and backpressure phases. A checker beside the
// block predicts and compares every result; this module only makes stimulus
// and decides.
// ----------------------------------------------------------------------------
module median_filter_3x3_tb;
   import mf3_pkg::*;

   localparam int     CLOCK_PERIOD  = 20;
   localparam int     RESET_CYCLES  = 6;
   localparam int     RANDOM_ITEMS  = 1500;
   localparam int     SETTLE_CYCLES = 12;
   localparam int     HOLD_CYCLES   = 400;
   localparam int     PHASE_ITEMS   = 200;
   localparam int     BURST_ITEMS   = 40;
   localparam longint WATCHDOG_NS   = 20_000_000;

   localparam logic [CSR_IDX_W-1:0] REG_SPARE_2 = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_3 = CSR_IDX_W'(3);

   typedef enum int unsigned {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_phase_e;
   typedef enum int unsigned {PIX_UNIFORM, PIX_CLUSTERED, PIX_EXTREMES} pixel_style_e;

   logic                 clock     = 1'b0;
   logic                 reset     = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   req_type              req_data  = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [DIM_W-1:0]     csr_wdata = '0;

   int pending_results;
   int results_checked;
   int frames_completed;
   int mismatch_count;

   int unsigned sender_idle_pct    = 0;
   int unsigned receiver_stall_pct = 0;
   bit          hold_request       = 1'b0;
   int unsigned items_offered      = 0;
   int unsigned random_items       = 0;
   int unsigned cur_w              = RESET_WIDTH;
   int unsigned cur_h              = RESET_HEIGHT;

   median_filter_3x3 dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   median_filter_3x3_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data         (rsp_data),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .pending_results  (pending_results),
      .results_checked  (results_checked),
      .frames_completed (frames_completed),
      .mismatch_count   (mismatch_count)
   );

   initial begin
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   initial begin : watchdog
      #(WATCHDOG_NS);
      $display("Timeout with %0d results still expected", pending_results);
      $display("Mismatches found");
      $finish;
   end

   // One long hold-off lets the block fill up and stall its input.
   initial begin : receiver
      bit held_once;
      held_once = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request && !held_once) begin
            held_once = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   task automatic send_item(input logic kind, input pixel_type pix);
      int unsigned gap;
      req_type     item;
      case (idle_phase_e'((items_offered / PHASE_ITEMS) % 4))
         IDLE_NONE: begin
            sender_idle_pct = 0;
            receiver_stall_pct <= 0;
         end
         IDLE_SENDER: begin
            sender_idle_pct = 71;
            receiver_stall_pct <= 0;
         end
         IDLE_RECEIVER: begin
            sender_idle_pct = 0;
            receiver_stall_pct <= 71;
         end
         default: begin
            sender_idle_pct = 11;
            receiver_stall_pct <= 11;
         end
      endcase
      gap = 0;
      while ($urandom_range(99) < sender_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      item.kind     = kind;
      item.pixel_in = pix;
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      items_offered++;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending_results != 0) @(negedge clock);
      @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] index, input logic [DIM_W-1:0] value);
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      if (index == REG_IMAGE_WIDTH) begin
         cur_w = (value < 2) ? 2 : (value > MAX_WIDTH) ? MAX_WIDTH : value;
      end else if (index == REG_IMAGE_HEIGHT) begin
         cur_h = (value < 2) ? 2 : (value > MAX_HEIGHT) ? MAX_HEIGHT : value;
      end
   endtask

   // Sends one frame at the current size: pixels, then the drain items. An
   // aborted frame stops at a random point and needs a register write after.
   task automatic run_frame(input bit abort, input bit pause_inside, input bit counted);
      int unsigned  n_pix;
      int unsigned  n_items;
      int unsigned  stop_at;
      pixel_style_e style;
      pixel_type    base;
      pixel_type    pix;
      n_pix   = cur_w * cur_h;
      n_items = n_pix + cur_w + 1;
      stop_at = abort ? $urandom_range(n_items - 1, 1) : n_items;
      style   = pixel_style_e'($urandom_range(2));
      base    = pixel_type'($urandom_range(255));
      for (int unsigned i = 0; i < stop_at; i++) begin
         if ((pause_inside && i == cur_w + 2) || $urandom_range(999) == 0) wait_drained();
         if (i < n_pix) begin
            case (style)
               PIX_UNIFORM:   pix = pixel_type'($urandom_range(255));
               PIX_CLUSTERED: pix = base + pixel_type'($urandom_range(3));
               default:       pix = $urandom_range(1) ? '1 : '0;
            endcase
            if ($urandom_range(99) < 4) send_item(KIND_FLUSH, pixel_type'($urandom_range(255)));
            send_item(KIND_PIXEL, pix);
         end else if ($urandom_range(99) < 25) begin
            send_item(KIND_PIXEL, pixel_type'($urandom_range(255)));
         end else begin
            send_item(KIND_FLUSH, pixel_type'($urandom_range(255)));
         end
         if (counted) random_items++;
      end
   endtask

   initial begin : stimulus
      int unsigned w_raw;
      int unsigned h_raw;
      bit          aborted;
      bit          first;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Smallest frame with sizes below range, an early flush, a pixel used
      // as a drain item and a flush ignored at the start of the next frame.
      write_reg(REG_IMAGE_WIDTH, 1);
      write_reg(REG_IMAGE_HEIGHT, 0);
      send_item(KIND_PIXEL, 8'hFF);
      send_item(KIND_FLUSH, 8'h00);
      send_item(KIND_PIXEL, 8'h00);
      send_item(KIND_PIXEL, 8'h80);
      send_item(KIND_PIXEL, 8'h01);
      send_item(KIND_FLUSH, 8'hFF);
      send_item(KIND_PIXEL, 8'hAA);
      send_item(KIND_FLUSH, 8'h00);
      send_item(KIND_FLUSH, 8'h55);

      // Writes to unused indexes only restart the frame.
      write_reg(REG_SPARE_2, 12'hFFF);
      write_reg(REG_SPARE_3, 12'h000);
      write_reg(REG_IMAGE_WIDTH, 3);
      send_item(KIND_PIXEL, 8'h00);
      send_item(KIND_PIXEL, 8'hFF);
      send_item(KIND_PIXEL, 8'h55);
      send_item(KIND_PIXEL, 8'hAA);
      send_item(KIND_PIXEL, 8'h0F);
      send_item(KIND_PIXEL, 8'hF0);
      repeat (cur_w + 1) send_item(KIND_FLUSH, 8'h00);

      // Sizes above the maximum; a short burst only starts such a frame.
      write_reg(REG_IMAGE_WIDTH, 12'hFFF);
      write_reg(REG_IMAGE_HEIGHT, 12'hFFF);
      repeat (BURST_ITEMS) send_item(KIND_PIXEL, pixel_type'($urandom_range(255)));

      hold_request <= 1'b1;
      first   = 1'b1;
      aborted = 1'b0;
      while (random_items < RANDOM_ITEMS) begin
         if (first || aborted || $urandom_range(99) < 70) begin
            w_raw = ($urandom_range(9) == 0) ? $urandom_range(64, 17) : $urandom_range(16, 2);
            h_raw = $urandom_range(6, 2);
            if ($urandom_range(19) == 0) w_raw = $urandom_range(1);
            if ($urandom_range(19) == 0) h_raw = $urandom_range(1);
            if ($urandom_range(9) == 0) begin
               write_reg($urandom_range(1) ? REG_SPARE_2 : REG_SPARE_3,
                         DIM_W'($urandom_range(4095)));
            end
            if ($urandom_range(1)) begin
               write_reg(REG_IMAGE_WIDTH, DIM_W'(w_raw));
               write_reg(REG_IMAGE_HEIGHT, DIM_W'(h_raw));
            end else begin
               write_reg(REG_IMAGE_HEIGHT, DIM_W'(h_raw));
               write_reg(REG_IMAGE_WIDTH, DIM_W'(w_raw));
            end
         end
         aborted = !first && ($urandom_range(99) < 8);
         run_frame(aborted, first || ($urandom_range(99) < 3), 1'b1);
         if (!aborted && $urandom_range(99) < 10) begin
            send_item(KIND_FLUSH, pixel_type'($urandom_range(255)));
         end
         first = 1'b0;
      end

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
      $display("Checked %0d filtered pixels over %0d complete frames from %0d items.",
               results_checked, frames_completed, items_offered);
      $display("Run covered edge replication, clamped sizes, ignored and reused items, %s",
               "aborted frames and idle and backpressure phases.");
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/core/mf3_pkg.sv
rtl/core/mf3_line_store.sv
rtl/core/mf3_median.sv
rtl/core/median_filter_3x3.sv
tb/median_filter_3x3_checker.sv
tb/median_filter_3x3_tb.sv
